[hdl/sbsc_pkg.sv]
// Shared types and codes for the slotted broadcast site controller.
// No dependencies; the top level and the port checker use it.
package sbsc_pkg;

    // Request kinds carried on the slave side tuser
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,   // slot deadline tick
        OP_MSG   = 2'd1,   // site message received
        OP_FAULT = 2'd2,   // fault or omission event
        OP_NONE  = 2'd3    // no defined meaning, ignored
    } opcode_t;

    // Protocol modes
    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,  // normal slotted operation
        MODE_FAULT = 2'd1,  // fault seen
        MODE_WAIT  = 2'd2,  // waiting for the slot owner's message
        MODE_OWN   = 2'd3   // fault recovery reached an owned slot
    } mode_t;

    // Result request fields, packed from bit 0 up
    localparam int RES_W     = 16;
    localparam int RES_ACC   = 0;
    localparam int RES_SEND  = 1;
    localparam int RES_SSEQ  = 2;   // 4 bits
    localparam int RES_MODE  = 6;   // 2 bits
    localparam int RES_SLOT  = 8;   // 4 bits
    localparam int RES_COMM  = 12;
    localparam int RES_MISM  = 13;

endpackage

[hdl/slotted_broadcast_site_controller.sv]
// An accepted request passes the input register and then the result register.
// Throughput: one request per cycle; the input register moves on whenever the
// result register is empty or being drained in the same cycle.
// Reset (rst_n, async, active low): mode 0, slot 0, all slot history clear,
// site_id 0, both pipeline registers empty. No clearing pass is needed.
// Depends on sbsc_pkg.
module slotted_broadcast_site_controller #(
    parameter int NUM_SITES   = 4,   // 2..16
    parameter int WRAP_FACTOR = 4    // 4..16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: site_id
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] rx_seq, [7:4] zero
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [0] accepted, [1] send, [5:2] send_seq,
                                    // [7:6] mode_now, [11:8] slot_now,
                                    // [12] committed, [13] seq_mismatch,
                                    // [15:14] zero
);

    // Slot counter wraps at SLOT_COUNT. A second counter tracks the slot
    // modulo NUM_SITES so ownership needs no divider: SLOT_COUNT is a
    // multiple of NUM_SITES, so both wrap together.
    localparam int SLOT_COUNT = WRAP_FACTOR * NUM_SITES;
    localparam int CW         = $clog2(SLOT_COUNT);
    localparam int OW         = $clog2(NUM_SITES);
    // The phase table is only ever looked at NUM_SITES slots behind the
    // counter, and every entry is cleared on arrival and only set while
    // it is the current slot. So a "received" flag for the current slot
    // plus a shift line of the NUM_SITES-1 previous slots holds all of it.
    localparam int HW         = NUM_SITES - 1;
    localparam logic [4:0] NS5 = 5'(NUM_SITES);

    // input register
    logic             in_valid_reg;
    sbsc_pkg::opcode_t in_op_reg;
    logic [3:0]       in_rx_reg;

    // result register
    logic             out_valid_reg;
    logic [sbsc_pkg::RES_W-1:0] out_data_reg, out_data_next;

    // block state
    logic [1:0]       site_id_reg;
    sbsc_pkg::mode_t  mode_reg, mode_next;
    logic [CW-1:0]    slot_reg, slot_next;
    logic [OW-1:0]    owner_reg, owner_next;
    logic             cur_rx_reg, cur_rx_next;
    logic [HW-1:0]    hist_reg, hist_next;

    logic             advance;
    logic             is_tick;
    logic [CW-1:0]    slot_inc;
    logic [OW-1:0]    owner_inc;
    logic [4:0]       site5, site_mod;
    logic             owns;

    // Handshake: input register refills while the result waits
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg <= sbsc_pkg::opcode_t'(s_tuser);
            in_rx_reg <= s_tdata[3:0];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    // state moves only when a request passes into the result register; site_id on cfg_we
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_id_reg <= 2'd0;
            mode_reg    <= sbsc_pkg::MODE_RUN;
            slot_reg    <= '0;
            owner_reg   <= '0;
            cur_rx_reg  <= 1'b0;
            hist_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                site_id_reg <= cfg_wdata;
            if (advance)
            begin
                mode_reg   <= mode_next;
                slot_reg   <= slot_next;
                owner_reg  <= owner_next;
                cur_rx_reg <= cur_rx_next;
                hist_reg   <= hist_next;
            end
        end
    end

    // slot arithmetic for a tick
    assign is_tick   = (in_op_reg == sbsc_pkg::OP_TICK);
    assign slot_inc  = (slot_reg == CW'(SLOT_COUNT - 1)) ? '0 : slot_reg + 1'b1;
    assign owner_inc = (owner_reg == OW'(NUM_SITES - 1)) ? '0 : owner_reg + 1'b1;
    assign slot_next  = is_tick ? slot_inc : slot_reg;
    assign owner_next = is_tick ? owner_inc : owner_reg;
    assign hist_next  = is_tick ? HW'({hist_reg, cur_rx_reg}) : hist_reg;

    // site_id mod NUM_SITES: site_id < 4 <= 2*NUM_SITES, one subtract at most
    assign site5    = {3'b000, site_id_reg};
    assign site_mod = (site5 >= NS5) ? site5 - NS5 : site5;
    // ownership of the slot being entered by a tick
    assign owns     = (5'(owner_inc) == site_mod);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (in_op_reg)
            sbsc_pkg::OP_TICK:
            begin
                case (mode_reg)
                    sbsc_pkg::MODE_RUN:
                        mode_next = owns ? sbsc_pkg::MODE_RUN : sbsc_pkg::MODE_WAIT;
                    sbsc_pkg::MODE_FAULT, sbsc_pkg::MODE_WAIT:
                        mode_next = owns ? sbsc_pkg::MODE_OWN : sbsc_pkg::MODE_FAULT;
                    default:
                        mode_next = mode_reg;
                endcase
            end
            sbsc_pkg::OP_MSG:
            begin
                if (mode_reg == sbsc_pkg::MODE_WAIT)
                    mode_next = sbsc_pkg::MODE_RUN;
            end
            sbsc_pkg::OP_FAULT:
            begin
                if (mode_reg inside {sbsc_pkg::MODE_RUN, sbsc_pkg::MODE_WAIT})
                    mode_next = sbsc_pkg::MODE_FAULT;
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    // result fields and current-slot flag
    always_comb
    begin
        logic       acc;
        logic       snd;
        logic       comm;
        logic       mism;
        acc         = 1'b0;
        snd         = 1'b0;
        comm        = 1'b0;
        mism        = 1'b0;
        cur_rx_next = cur_rx_reg;
        case (in_op_reg)
            sbsc_pkg::OP_TICK:
            begin
                acc         = 1'b1;
                cur_rx_next = 1'b0;   // new slot starts clear
                if (mode_reg == sbsc_pkg::MODE_RUN)
                begin
                    comm = hist_reg[HW-1];   // slot NUM_SITES back was received
                    if (owns)
                    begin
                        snd         = 1'b1;
                        cur_rx_next = 1'b1;
                    end
                end
            end
            sbsc_pkg::OP_MSG:
            begin
                acc = 1'b1;
                if (mode_reg == sbsc_pkg::MODE_WAIT)
                begin
                    mism        = (in_rx_reg != 4'(slot_reg));
                    cur_rx_next = 1'b1;
                end
            end
            sbsc_pkg::OP_FAULT:
                acc = (mode_reg inside {sbsc_pkg::MODE_RUN, sbsc_pkg::MODE_WAIT});
            default:
                acc = 1'b0;
        endcase

        out_data_next = '0;
        out_data_next[sbsc_pkg::RES_ACC]                   = acc;
        out_data_next[sbsc_pkg::RES_SEND]                  = snd;
        out_data_next[sbsc_pkg::RES_SSEQ +: 4]             = snd ? 4'(slot_next) : 4'd0;
        out_data_next[sbsc_pkg::RES_MODE +: 2]             = mode_next;
        out_data_next[sbsc_pkg::RES_SLOT +: 4]             = 4'(slot_next);
        out_data_next[sbsc_pkg::RES_COMM]                  = comm;
        out_data_next[sbsc_pkg::RES_MISM]                  = mism;
    end

endmodule

[hdl/sbsc_checker.sv]
// Port-level checks for the slotted broadcast site controller result stream.
// Depends on sbsc_pkg; bound to slotted_broadcast_site_controller below.
module sbsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a broadcast only from normal mode, numbered with the current slot
    a_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[sbsc_pkg::RES_SEND] |->
            m_tdata[sbsc_pkg::RES_ACC] &&
            m_tdata[sbsc_pkg::RES_MODE +: 2] == sbsc_pkg::MODE_RUN &&
            m_tdata[sbsc_pkg::RES_SSEQ +: 4] == m_tdata[sbsc_pkg::RES_SLOT +: 4])
        else $error("broadcast inconsistent with mode or slot");

    // no broadcast, no sequence number
    a_nosend: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[sbsc_pkg::RES_SEND] |->
            m_tdata[sbsc_pkg::RES_SSEQ +: 4] == 4'd0)
        else $error("send_seq set without send");

    // mismatch only on an accepted message that returned to normal mode
    a_mism: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[sbsc_pkg::RES_MISM] |->
            m_tdata[sbsc_pkg::RES_ACC] &&
            m_tdata[sbsc_pkg::RES_MODE +: 2] == sbsc_pkg::MODE_RUN &&
            !m_tdata[sbsc_pkg::RES_COMM])
        else $error("seq_mismatch outside a message in wait mode");

    // promotion only on a tick taken in normal mode
    a_comm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[sbsc_pkg::RES_COMM] |->
            m_tdata[sbsc_pkg::RES_ACC] &&
            (m_tdata[sbsc_pkg::RES_MODE +: 2] == sbsc_pkg::MODE_RUN ||
             m_tdata[sbsc_pkg::RES_MODE +: 2] == sbsc_pkg::MODE_WAIT))
        else $error("commit outside normal mode tick");

endmodule

bind slotted_broadcast_site_controller sbsc_checker u_sbsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/sbsc_result_checker.sv]
// Result checker for the slotted broadcast site controller: tracks site_id writes,
// predicts each result from accepted requests and compares it field by field.
// Depends on sbsc_pkg.
module sbsc_result_checker #(
    parameter int NUM_SITES   = 4,
    parameter int WRAP_FACTOR = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          error_count,
    output int          outstanding
);

    localparam int SLOT_COUNT = NUM_SITES * WRAP_FACTOR;

    // slot history codes
    localparam logic [1:0] PH_CLEAR     = 2'd0;
    localparam logic [1:0] PH_COMMITTED = 2'd1;
    localparam logic [1:0] PH_RECEIVED  = 2'd3;

    typedef struct packed {
        logic              accepted;
        logic              send;
        logic [3:0]        send_seq;
        sbsc_pkg::mode_t   mode_now;
        logic [3:0]        slot_now;
        logic              committed;
        logic              seq_mismatch;
    } slot_result_t;

    logic [1:0]      own_id;
    sbsc_pkg::mode_t cur_mode;
    int              cur_slot;
    logic [1:0]      slot_history [SLOT_COUNT];
    slot_result_t    pending_results [$];

    function automatic bit owns_current();
        return (cur_slot % NUM_SITES) == (int'(own_id) % NUM_SITES);
    endfunction

    // Applies one request to the shadow state and returns the result it causes.
    function automatic slot_result_t advance_event(sbsc_pkg::opcode_t op, logic [3:0] rx);
        slot_result_t r;
        int           back;
        r = '0;
        case (op)
            sbsc_pkg::OP_TICK:
            begin
                r.accepted = 1'b1;
                cur_slot = (cur_slot + 1) % SLOT_COUNT;
                slot_history[cur_slot] = PH_CLEAR;
                if (cur_mode == sbsc_pkg::MODE_RUN)
                begin
                    back = (cur_slot + SLOT_COUNT - NUM_SITES) % SLOT_COUNT;
                    if (slot_history[back] != PH_CLEAR)
                    begin
                        slot_history[back] = PH_COMMITTED;
                        r.committed = 1'b1;
                    end
                    if (owns_current())
                    begin
                        r.send = 1'b1;
                        r.send_seq = cur_slot[3:0];
                        slot_history[cur_slot] = PH_RECEIVED;
                    end
                    else
                        cur_mode = sbsc_pkg::MODE_WAIT;
                end
                else if (cur_mode == sbsc_pkg::MODE_FAULT || cur_mode == sbsc_pkg::MODE_WAIT)
                    cur_mode = owns_current() ? sbsc_pkg::MODE_OWN : sbsc_pkg::MODE_FAULT;
            end
            sbsc_pkg::OP_MSG:
            begin
                r.accepted = 1'b1;
                if (cur_mode == sbsc_pkg::MODE_WAIT)
                begin
                    r.seq_mismatch = (rx != cur_slot[3:0]);
                    slot_history[cur_slot] = PH_RECEIVED;
                    cur_mode = sbsc_pkg::MODE_RUN;
                end
            end
            sbsc_pkg::OP_FAULT:
            begin
                if (cur_mode == sbsc_pkg::MODE_RUN || cur_mode == sbsc_pkg::MODE_WAIT)
                begin
                    cur_mode = sbsc_pkg::MODE_FAULT;
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.mode_now = cur_mode;
        r.slot_now = cur_slot[3:0];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t want;
        if (!rst_n)
        begin
            own_id = 2'd0;
            cur_mode = sbsc_pkg::MODE_RUN;
            cur_slot = 0;
            foreach (slot_history[i])
                slot_history[i] = PH_CLEAR;
            pending_results.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                own_id = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("accepted", want.accepted, m_tdata[sbsc_pkg::RES_ACC]);
                    check_field("send", want.send, m_tdata[sbsc_pkg::RES_SEND]);
                    check_field("send_seq", want.send_seq,
                                m_tdata[sbsc_pkg::RES_SSEQ +: 4]);
                    check_field("mode_now", want.mode_now,
                                m_tdata[sbsc_pkg::RES_MODE +: 2]);
                    check_field("slot_now", want.slot_now,
                                m_tdata[sbsc_pkg::RES_SLOT +: 4]);
                    check_field("committed", want.committed, m_tdata[sbsc_pkg::RES_COMM]);
                    check_field("seq_mismatch", want.seq_mismatch,
                                m_tdata[sbsc_pkg::RES_MISM]);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                    advance_event(sbsc_pkg::opcode_t'(s_tuser), s_tdata[3:0]));
            outstanding = pending_results.size();
        end
    end

endmodule

[verif/slotted_broadcast_site_controller_tb.sv]
// Testbench top for the slotted broadcast site controller: drives requests and
// site_id writes, randomizes both handshakes and reports the verdict.
// Depends on sbsc_pkg, sbsc_result_checker and the controller RTL.
module slotted_broadcast_site_controller_tb;

    localparam int NUM_SITES   = 4;
    localparam int WRAP_FACTOR = 4;
    localparam int SLOT_COUNT  = NUM_SITES * WRAP_FACTOR;
    // quiet cycles allowed before giving up
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_LEN   = 130;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [3:0] rx_seq, [7:4] zero
    logic [1:0]  s_tuser;      // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [0] accepted, [1] send, [5:2] send_seq, [7:6] mode_now,
                               // [11:8] slot_now, [12] committed, [13] seq_mismatch

    int          error_count;
    int          outstanding;
    int          quiet_cycles;
    int          sent;         // requests accepted so far
    int          slot_track;   // slot counter, followed from the ticks sent
    logic [1:0]  site_sel;     // site_id last written
    bit          idle_en;      // random gaps on both sides

    initial clk = 1'b0;
    always #4 clk = ~clk;

    slotted_broadcast_site_controller #(
        .NUM_SITES  (NUM_SITES),
        .WRAP_FACTOR(WRAP_FACTOR)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sbsc_result_checker #(
        .NUM_SITES  (NUM_SITES),
        .WRAP_FACTOR(WRAP_FACTOR)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .error_count(error_count),
        .outstanding(outstanding)
    );

    // Result side back-pressure: about one stalled cycle in four while idling is on.
    always @(negedge clk)
        m_tready = !idle_en || ($urandom_range(99) >= 25);

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("slotted_broadcast_site_controller_tb: FAIL");
            $finish;
        end
    end

    // Offers one request, with a random gap ahead of it, and waits for the handshake.
    // Valid stays high afterwards; the next gap or a drain lowers it.
    task automatic push_request(sbsc_pkg::opcode_t op, logic [3:0] rx);
        while (idle_en && $urandom_range(99) < 25)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'h0, rx};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
        if (op == sbsc_pkg::OP_TICK)
            slot_track = (slot_track + 1) % SLOT_COUNT;
    endtask

    // Sender holds off until every result has come back, then lets the pipe settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_site_id(logic [1:0] id);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = id;
        @(negedge clk);
        cfg_we    = 1'b0;
        site_sel  = id;
    endtask

    function automatic bit next_owned();
        return ((slot_track + 1) % NUM_SITES) == (int'(site_sel) % NUM_SITES);
    endfunction

    // One slot of normal traffic from run mode: the tick, and when another site owns
    // the slot, that site's message (mostly with the right sequence number). Ignored
    // requests, also while waiting, and stray messages in run mode are sprinkled in as noise;
    // they never change the mode, so the controller stays out of the fault path.
    task automatic slot_sequence();
        bit waiting;
        waiting = !next_owned();
        if ($urandom_range(9) == 0)
            push_request(sbsc_pkg::OP_NONE, 4'($urandom));
        if ($urandom_range(9) == 0)
            push_request(sbsc_pkg::OP_MSG, 4'($urandom));
        push_request(sbsc_pkg::OP_TICK, 4'($urandom));
        if (waiting)
        begin
            if ($urandom_range(9) == 0)
                push_request(sbsc_pkg::OP_NONE, 4'($urandom));
            push_request(sbsc_pkg::OP_MSG,
                         ($urandom_range(4) == 0) ? 4'($urandom) : 4'(slot_track));
        end
    endtask

    initial
    begin
        logic [1:0] phase_ids [6];
        int         phase_end;
        phase_ids = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 2'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = sbsc_pkg::OP_NONE;
        m_tready   = 1'b0;
        idle_en    = 1'b1;
        sent       = 0;
        slot_track = 0;
        site_sel   = 2'd0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening with site 0: ignored opcode, message outside wait mode,
        // matched and mismatched messages, an owned slot that broadcasts, and a
        // later tick that promotes a received slot to committed.
        write_site_id(2'd0);
        push_request(sbsc_pkg::OP_NONE, 4'hF);
        push_request(sbsc_pkg::OP_MSG, 4'h0);
        push_request(sbsc_pkg::OP_TICK, 4'h0);    // slot 1, owner elsewhere -> wait
        push_request(sbsc_pkg::OP_NONE, 4'h5);    // ignored while waiting
        push_request(sbsc_pkg::OP_MSG, 4'h1);     // right sequence number
        push_request(sbsc_pkg::OP_TICK, 4'hF);    // slot 2
        push_request(sbsc_pkg::OP_MSG, 4'hF);     // wrong sequence number, still received
        push_request(sbsc_pkg::OP_TICK, 4'h0);    // slot 3
        push_request(sbsc_pkg::OP_MSG, 4'h3);
        push_request(sbsc_pkg::OP_TICK, 4'h0);    // slot 4, own slot -> broadcast
        push_request(sbsc_pkg::OP_TICK, 4'h0);    // slot 5, slot 1 gets committed
        push_request(sbsc_pkg::OP_MSG, 4'hA);

        // Random slots under several site ids, each phase started from an empty pipe.
        // Phase 2 runs with no gaps on either side.
        for (int p = 0; p < 6; p++)
        begin
            write_site_id(phase_ids[p]);
            idle_en = (p != 2);
            phase_end = sent + PHASE_LEN;
            while (sent < phase_end)
                slot_sequence();
        end
        idle_en = 1'b1;

        // Fault path last: once the own-slot mode is reached nothing but reset leaves
        // it. Enter the fault path by a fault in run mode, a fault while waiting, or a second
        // tick while waiting, chosen at random.
        case ($urandom_range(2))
            0: push_request(sbsc_pkg::OP_FAULT, 4'($urandom));
            1:
            begin
                while (next_owned())
                    push_request(sbsc_pkg::OP_TICK, 4'($urandom));
                push_request(sbsc_pkg::OP_TICK, 4'($urandom));
                push_request(sbsc_pkg::OP_FAULT, 4'($urandom));
            end
            default:
            begin
                while (next_owned())
                    push_request(sbsc_pkg::OP_TICK, 4'($urandom));
                push_request(sbsc_pkg::OP_TICK, 4'($urandom));
                push_request(sbsc_pkg::OP_TICK, 4'($urandom));
            end
        endcase
        push_request(sbsc_pkg::OP_FAULT, 4'h0);   // refused outside run and wait modes
        push_request(sbsc_pkg::OP_MSG, 4'hF);
        push_request(sbsc_pkg::OP_NONE, 4'h0);
        repeat (NUM_SITES + 1) push_request(sbsc_pkg::OP_TICK, 4'h0);   // reaches an owned slot
        push_request(sbsc_pkg::OP_FAULT, 4'h0);
        push_request(sbsc_pkg::OP_MSG, 4'h5);

        // Unstructured noise in the terminal mode.
        phase_end = sent + 60;
        while (sent < phase_end)
            push_request(sbsc_pkg::opcode_t'($urandom_range(3)), 4'($urandom));

        drain();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("slotted_broadcast_site_controller_tb: PASS");
        else
            $display("slotted_broadcast_site_controller_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/sbsc_pkg.sv
hdl/slotted_broadcast_site_controller.sv
hdl/sbsc_checker.sv
verif/sbsc_result_checker.sv
verif/slotted_broadcast_site_controller_tb.sv
